@@ hdl/hnrc_pkg.sv @@
// ============================================================================
// Hue nearest-reference classifier: shared package
// Widths, packed types and hue constants used by the lane, merge and top files.
// ============================================================================
package hnrc_pkg;

    // Item geometry
    localparam int PIX_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int NUM_REFS  = 4;
    localparam int NUM_PIX   = NUM_REFS + 1;
    localparam int HUE_W     = 9;
    localparam int CLASS_W   = 2;

    // Sector offset divider: 60 * |x - y| / d, quotient at most 60
    localparam int QUOT_W    = 6;
    localparam int DIV_STEPS = QUOT_W;
    localparam int REM_W     = CHAN_W + QUOT_W;

    // Pipeline depth from the input word to the merged result
    localparam int LANE_DEPTH  = DIV_STEPS + 2;
    localparam int MERGE_DEPTH = 2;
    localparam int PIPE_DEPTH  = LANE_DEPTH + MERGE_DEPTH;

    // Word packing
    localparam int IN_DATA_W  = NUM_PIX * PIX_W;
    localparam int RES_W      = CLASS_W + 2 * HUE_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_DATA_W - RES_W;

    // Sector base angles
    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;

    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [CLASS_W-1:0] class_t;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // One stage of the per-lane hue pipeline
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
        logic [CHAN_W-1:0] span;
        logic              neg;
        logic              grey;
        sector_t           sector;
    } div_stage_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        hue_t   hue_distance;
        hue_t   center_hue;
        class_t level_class;
    } result_t;

endpackage

@@ hdl/hnrc_hue_lane.sv @@
// ============================================================================
// Hue lane
// Converts one RGB pixel to integer hue degrees through a restoring divider
// that resolves one quotient bit per stage.
// ============================================================================
module hnrc_hue_lane (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [hnrc_pkg::PIX_W-1:0]  pixel,
    output hnrc_pkg::hue_t              hue
);
    import hnrc_pkg::*;

    logic [CHAN_W-1:0] r, g, b, mx, mn, x, y, a;
    logic [REM_W-1:0]  a_wide;
    div_stage_t        stage_reg  [DIV_STEPS+1];
    div_stage_t        stage_next [DIV_STEPS+1];
    logic [QUOT_W:0]   mag;
    hue_t              mag9;
    hue_t              hue_reg, hue_next;

    // Split the pixel, find the extremes and the sector, and scale the offset by 60.
    always_comb begin
        r = pixel[CHAN_W-1:0];
        g = pixel[2*CHAN_W-1:CHAN_W];
        b = pixel[3*CHAN_W-1:2*CHAN_W];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        stage_next[0].span = mx - mn;
        stage_next[0].grey = (mx == mn);
        if (mx == r) begin
            stage_next[0].sector = SEC_RED;
            x = g;
            y = b;
        end else if (mx == g) begin
            stage_next[0].sector = SEC_GREEN;
            x = b;
            y = r;
        end else begin
            stage_next[0].sector = SEC_BLUE;
            x = r;
            y = g;
        end
        stage_next[0].neg = (x < y);
        a = (x < y) ? (y - x) : (x - y);
        a_wide = REM_W'(a);
        // 60 * a as 64 * a - 4 * a
        stage_next[0].rem  = (a_wide << 6) - (a_wide << 2);
        stage_next[0].quot = '0;
    end

    // Divider steps, most significant quotient bit first.
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        logic [REM_W-1:0] trial;
        always_comb begin
            trial = REM_W'(stage_reg[j-1].span) << (DIV_STEPS - j);
            stage_next[j] = stage_reg[j-1];
            if (stage_reg[j-1].rem >= trial) begin
                stage_next[j].rem  = stage_reg[j-1].rem - trial;
                stage_next[j].quot = stage_reg[j-1].quot | (QUOT_W'(1) << (DIV_STEPS - j));
            end
        end
    end

    // A negative offset floors away from zero, so a remainder adds one.
    always_comb begin
        mag  = {1'b0, stage_reg[DIV_STEPS].quot} +
               (QUOT_W+1)'(stage_reg[DIV_STEPS].neg && (stage_reg[DIV_STEPS].rem != '0));
        mag9 = HUE_W'(mag);
        hue_next = '0;
        if (!stage_reg[DIV_STEPS].grey) begin
            case (stage_reg[DIV_STEPS].sector)
                SEC_RED:   hue_next = stage_reg[DIV_STEPS].neg ? (HUE_FULL - mag9) : mag9;
                SEC_GREEN: hue_next = stage_reg[DIV_STEPS].neg ? (HUE_GREEN - mag9)
                                                               : (HUE_GREEN + mag9);
                SEC_BLUE:  hue_next = stage_reg[DIV_STEPS].neg ? (HUE_BLUE - mag9)
                                                               : (HUE_BLUE + mag9);
                default:   hue_next = '0;
            endcase
        end
    end

    // Pipeline registers advance together under the shared enable.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                stage_reg[i] <= stage_next[i];
            end
            hue_reg <= hue_next;
        end
    end

    assign hue = hue_reg;

endmodule

@@ hdl/hnrc_merge.sv @@
// ============================================================================
// Lane merge
// Measures the hue distances of the references to the centre and picks the
// nearest one, the lower index winning a tie.
// ============================================================================
module hnrc_merge (
    input  logic                 aclk,
    input  logic                 en,
    input  hnrc_pkg::hue_t       ref_hue [hnrc_pkg::NUM_REFS],
    input  hnrc_pkg::hue_t       center_hue,
    output hnrc_pkg::result_t    result
);
    import hnrc_pkg::*;

    hue_t    dist_reg [NUM_REFS];
    hue_t    dist_next [NUM_REFS];
    hue_t    center_reg;
    hue_t    d01, d23;
    class_t  w01, w23;
    result_t result_reg, result_next;

    // Absolute distance per reference.
    always_comb begin
        for (int k = 0; k < NUM_REFS; k++) begin
            dist_next[k] = (ref_hue[k] > center_hue) ? (ref_hue[k] - center_hue)
                                                     : (center_hue - ref_hue[k]);
        end
    end

    // Two-level minimum tree; the right side wins only when strictly nearer.
    always_comb begin
        if (dist_reg[1] < dist_reg[0]) begin
            w01 = class_t'(1);
            d01 = dist_reg[1];
        end else begin
            w01 = class_t'(0);
            d01 = dist_reg[0];
        end
        if (dist_reg[3] < dist_reg[2]) begin
            w23 = class_t'(3);
            d23 = dist_reg[3];
        end else begin
            w23 = class_t'(2);
            d23 = dist_reg[2];
        end
        result_next.center_hue = center_reg;
        if (d23 < d01) begin
            result_next.level_class  = w23;
            result_next.hue_distance = d23;
        end else begin
            result_next.level_class  = w01;
            result_next.hue_distance = d01;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg   <= dist_next;
            center_reg <= center_hue;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/hue_nearest_reference_classifier.sv @@
// ============================================================================
// Hue nearest-reference classifier
// Five hue lanes and a merge stage classify a centre pixel by the nearest
// reference hue.
// ============================================================================
// Usage:
//   The slave channel takes one word per cycle holding five 24-bit pixels:
//   left, right, upper and lower references and then the centre sample.
//   The master channel returns one word per input word, in order, with the
//   index of the nearest reference, the centre hue and the hue distance.
//   From the accepting edge to m_tvalid a word passes the hue lanes (one
//   set-up stage, six divider stages of one quotient bit each and the hue
//   stage), the merge registers and the output register. Throughput is
//   one word per cycle while the skid register is empty; the divider
//   steps are the pipeline. While the receiver stalls, one further word
//   is caught in a skid register and s_tready then drops until it drains;
//   s_tready comes straight from a register. Reset clears all valid
//   flags, the pipeline comes up empty and s_tready is high after reset.
// ============================================================================
module hue_nearest_reference_classifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_pixel, right_pixel, upper_pixel, lower_pixel, center_pixel
    input  logic [hnrc_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // level_class, center_hue, hue_distance, zero padding
    output logic [hnrc_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import hnrc_pkg::*;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    hue_t                  ref_hue [NUM_REFS];
    hue_t                  center_hue;
    result_t               pipe_result;
    logic                  pipe_fire;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    result_t               out_reg, out_next;
    result_t               skid_reg, skid_next;

    // The whole pipeline moves whenever the skid register is free.
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // Reference lanes.
    for (genvar k = 0; k < NUM_REFS; k++) begin : g_ref
        hnrc_hue_lane u_lane (
            .aclk  (aclk),
            .en    (adv),
            .pixel (s_tdata[k*PIX_W +: PIX_W]),
            .hue   (ref_hue[k])
        );
    end

    // Centre lane.
    hnrc_hue_lane u_center (
        .aclk  (aclk),
        .en    (adv),
        .pixel (s_tdata[NUM_REFS*PIX_W +: PIX_W]),
        .hue   (center_hue)
    );

    hnrc_merge u_merge (
        .aclk       (aclk),
        .en         (adv),
        .ref_hue    (ref_hue),
        .center_hue (center_hue),
        .result     (pipe_result)
    );

    // Valid flags follow the words down the pipeline.
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // Output register with a one-word skid buffer.
    assign pipe_fire = valid_reg[PIPE_DEPTH-1] && adv;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (m_tready || !out_valid_reg) begin
            out_valid_next  = skid_valid_reg || pipe_fire;
            out_next        = skid_valid_reg ? skid_reg : pipe_result;
            skid_valid_next = 1'b0;
        end else if (pipe_fire) begin
            skid_valid_next = 1'b1;
            skid_next       = pipe_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_reg};

endmodule

@@ tb/tb_hue_nearest_reference_classifier.sv @@
// ----------------------------------------------------------------------------
// Testbench for the hue nearest-reference classifier
// Drives five-pixel words into the slave channel under changing sender and
// receiver idling. Each result word is checked field by field against an
// in-order queue of expected results, from the directed table or a local hue predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hue_nearest_reference_classifier;
    import hnrc_pkg::*;

    typedef logic [NUM_PIX-1:0][PIX_W-1:0] pix_set_t;

    // One row of the directed table; res is used only when known is set
    typedef struct {
        pix_set_t pix;
        bit       known;
        result_t  res;
    } stim_row_t;

    // Reference indexes as the block reports them
    localparam class_t CLS_ALERT = 2'd0;
    localparam class_t CLS_TOXIC = 2'd1;
    localparam class_t CLS_ALARM = 2'd2;
    localparam class_t CLS_SAFE  = 2'd3;

    // Colours, red in the low byte
    localparam logic [PIX_W-1:0] COL_BLACK   = 24'h000000;
    localparam logic [PIX_W-1:0] COL_WHITE   = 24'hFFFFFF;
    localparam logic [PIX_W-1:0] COL_RED     = 24'h0000FF;
    localparam logic [PIX_W-1:0] COL_GREEN   = 24'h00FF00;
    localparam logic [PIX_W-1:0] COL_BLUE    = 24'hFF0000;
    localparam logic [PIX_W-1:0] COL_YELLOW  = 24'h00FFFF;
    localparam logic [PIX_W-1:0] COL_CYAN    = 24'hFFFF00;
    localparam logic [PIX_W-1:0] COL_MAGENTA = 24'hFF00FF;
    // Red with a trace of blue: the highest hue, 359 degrees
    localparam logic [PIX_W-1:0] COL_RED_TOP = 24'h0100FF;

    localparam int RANDOM_PER_PHASE = 425;
    localparam int NUM_PHASES       = 4;
    localparam int HOLD_OFF_CYCLES  = 80;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int MAX_REPORTS      = 10;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    result_t expected_classes[$];
    int      sender_idle_pct = 0;
    int      sink_stall_pct  = 0;
    int      hold_left       = 0;
    int      words_sent      = 0;
    int      results_checked = 0;
    int      mismatches      = 0;
    int      cycle_count     = 0;

    hue_nearest_reference_classifier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Integer hue of one pixel: floor of the exact sector formula
    function automatic hue_t hue_degrees(logic [PIX_W-1:0] px);
        int unsigned r, g, b, hi, lo, span, num, h;
        r  = px[7:0];
        g  = px[15:8];
        b  = px[23:16];
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        if (hi == lo) return '0;
        span = hi - lo;
        // Sector priority is red, then green, then blue
        if (hi == r) begin
            num = 360 * span + 60 * g - 60 * b;
            h   = num / span;
            if (h >= 360) h = h - 360;
        end else if (hi == g) begin
            num = 120 * span + 60 * b - 60 * r;
            h   = num / span;
        end else begin
            num = 240 * span + 60 * r - 60 * g;
            h   = num / span;
        end
        return hue_t'(h);
    endfunction

    // Nearest reference by plain hue distance, lowest index on a tie
    function automatic result_t classify_centre(pix_set_t p);
        result_t     res;
        int unsigned ch, rh, ref_dist, best_dist;
        int          best;
        ch        = hue_degrees(p[NUM_REFS]);
        best      = 0;
        best_dist = 0;
        for (int k = 0; k < NUM_REFS; k++) begin
            rh       = hue_degrees(p[k]);
            ref_dist = (rh > ch) ? rh - ch : ch - rh;
            if (k == 0 || ref_dist < best_dist) begin
                best_dist = ref_dist;
                best      = k;
            end
        end
        res.level_class  = class_t'(best);
        res.center_hue   = hue_t'(ch);
        res.hue_distance = hue_t'(best_dist);
        return res;
    endfunction

    // Random pixel of one of several shapes: raw, grey, saturated,
    // a shared largest channel, or nearly grey
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [CHAN_W-1:0] ch [3];
        int                hi, lo, k, base;
        case ($urandom_range(0, 5))
            0, 1: begin
                return PIX_W'($urandom);
            end
            2: begin
                ch[0] = CHAN_W'($urandom_range(0, 255));
                ch[1] = ch[0];
                ch[2] = ch[0];
            end
            3: begin
                for (int i = 0; i < 3; i++) ch[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                ch[$urandom_range(0, 2)] = CHAN_W'($urandom_range(0, 255));
            end
            4: begin
                hi = $urandom_range(1, 255);
                lo = $urandom_range(0, hi - 1);
                k  = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) ch[i] = CHAN_W'(hi);
                ch[k] = CHAN_W'(lo);
            end
            default: begin
                base = $urandom_range(0, 252);
                for (int i = 0; i < 3; i++) ch[i] = CHAN_W'(base + $urandom_range(0, 3));
            end
        endcase
        return {ch[2], ch[1], ch[0]};
    endfunction

    // Five pixels where references often repeat or shadow the centre,
    // so that ties and small distances come up often
    function automatic pix_set_t random_pixel_set();
        pix_set_t p;
        int       src;
        p[NUM_REFS] = random_pixel();
        for (int k = 0; k < NUM_REFS; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    p[k] = p[NUM_REFS] ^ PIX_W'($urandom_range(0, 3));
                2: begin
                    // Repeat the centre or a reference that is already set.
                    src  = $urandom_range(0, k);
                    p[k] = (src == k) ? p[NUM_REFS] : p[src];
                end
                default: p[k] = random_pixel();
            endcase
        end
        return p;
    endfunction

    // Offer one word, with random idle cycles first, and record its result
    task automatic send_word(pix_set_t p, bit known, result_t typed);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        expected_classes.push_back(known ? typed : classify_centre(p));
        words_sent++;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_classes.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, or a long hold-off while hold_left runs down
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Result checking against the oldest expectation
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (expected_classes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result word with nothing expected: class %0d hue %0d dist %0d",
                             $realtime, got.level_class, got.center_hue, got.hue_distance);
            end else begin
                want = expected_classes.pop_front();
                results_checked++;
                if (got.level_class !== want.level_class || got.center_hue !== want.center_hue
                        || got.hue_distance !== want.hue_distance) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("[%0t] mismatch: expected class %0d hue %0d dist %0d,", $realtime,
                               want.level_class, want.center_hue, want.hue_distance);
                        $display(" got class %0d hue %0d dist %0d",
                                 got.level_class, got.center_hue, got.hue_distance);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_classes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t directed_rows[$];
        result_t   unused_res;

        unused_res = '0;

        // Directed table: centre is the top pixel, left reference the bottom one
        // All grey: every hue is zero
        directed_rows.push_back('{{COL_BLACK, COL_BLACK, COL_BLACK, COL_BLACK, COL_BLACK},
                                  1'b1, {9'd0, 9'd0, CLS_ALERT}});
        directed_rows.push_back('{{COL_WHITE, COL_WHITE, COL_WHITE, COL_WHITE, COL_WHITE},
                                  1'b1, {9'd0, 9'd0, CLS_ALERT}});
        // Primaries and yellow as references
        directed_rows.push_back('{{COL_GREEN, COL_YELLOW, COL_BLUE, COL_GREEN, COL_RED},
                                  1'b1, {9'd0, 9'd120, CLS_TOXIC}});
        // Equal distances to two references: the lower index wins
        directed_rows.push_back('{{COL_BLUE, COL_BLUE, COL_BLUE, COL_GREEN, COL_RED},
                                  1'b1, {9'd0, 9'd240, CLS_ALARM}});
        // Only the lower reference matches
        directed_rows.push_back('{{COL_BLUE, COL_BLUE, COL_GREEN, COL_GREEN, COL_RED},
                                  1'b1, {9'd0, 9'd240, CLS_SAFE}});
        directed_rows.push_back('{{COL_GREEN, COL_GREEN, COL_GREEN, COL_GREEN, COL_GREEN},
                                  1'b1, {9'd0, 9'd120, CLS_ALERT}});
        directed_rows.push_back('{{COL_RED, COL_BLUE, COL_GREEN, COL_BLACK, COL_MAGENTA},
                                  1'b1, {9'd0, 9'd0, CLS_TOXIC}});
        directed_rows.push_back('{{COL_YELLOW, COL_MAGENTA, COL_CYAN, COL_GREEN, COL_RED},
                                  1'b1, {9'd60, 9'd60, CLS_ALERT}});
        directed_rows.push_back('{{COL_CYAN, COL_MAGENTA, COL_BLUE, COL_GREEN, COL_YELLOW},
                                  1'b1, {9'd60, 9'd180, CLS_TOXIC}});
        // No circular wrap: 359 degrees is far from 0
        directed_rows.push_back('{{COL_RED, COL_CYAN, COL_CYAN, COL_CYAN, COL_RED_TOP},
                                  1'b1, {9'd180, 9'd0, CLS_TOXIC}});
        directed_rows.push_back('{{COL_RED, COL_RED_TOP, COL_RED_TOP, COL_RED_TOP, COL_RED_TOP},
                                  1'b1, {9'd359, 9'd0, CLS_ALERT}});
        directed_rows.push_back('{{COL_RED_TOP, COL_BLACK, COL_YELLOW, COL_WHITE, COL_RED_TOP},
                                  1'b1, {9'd0, 9'd359, CLS_ALERT}});
        // Mixed colours, shared largest channels and near-grey pixels
        directed_rows.push_back('{{24'h123456, 24'hFEDCBA, 24'h80FF7F, 24'h01FE00, 24'hFF0001},
                                  1'b0, unused_res});
        directed_rows.push_back('{{24'h00FF01, 24'hAAAAAB, 24'h555554, 24'h7F7F80, 24'h000180},
                                  1'b0, unused_res});
        directed_rows.push_back('{{24'hFFFFFE, 24'h00FFFE, 24'hFEFF00, 24'hFF00FE, 24'h010000},
                                  1'b0, unused_res});
        directed_rows.push_back('{{24'h808080, 24'h0080FF, 24'hFF8000, 24'h80FF00, 24'h00FF80},
                                  1'b0, unused_res});
        directed_rows.push_back('{{24'h0F1E2D, 24'hC3B2A1, 24'h5A6B7C, 24'hE1D2C3, 24'h3C4B5A},
                                  1'b0, unused_res});
        directed_rows.push_back('{{24'hFE0001, 24'h0001FE, 24'h01FE00, 24'h000101, 24'h010100},
                                  1'b0, unused_res});

        // Hold the synchronous reset at the start, then release it
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words with both sides always ready
        foreach (directed_rows[i])
            send_word(directed_rows[i].pix, directed_rows[i].known, directed_rows[i].res);
        drain_pipeline();

        // Random words in phases of idling: none, sender, receiver, both
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 52; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin sender_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Long receiver hold-off so that the pipeline fills and backs up
                if ((ph == 0 && n == 150) || (ph == 3 && n == 200))
                    hold_left = HOLD_OFF_CYCLES;
                send_word(random_pixel_set(), 1'b0, unused_res);
            end
            drain_pipeline();
        end

        // Let any stray word appear before the verdict
        repeat (PIPE_DEPTH + 5) @(posedge aclk);

        $display("Classified %0d five-pixel words (%0d results checked, %0d mismatches),",
                 words_sent, results_checked, mismatches);
        $display("covering grey, saturated, tied and random colours under four idling mixes.");
        if (mismatches == 0 && expected_classes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
